FILE: rtl/ola_pkg.sv
// Shared constants and types for the ordered list engine.
// Used by ordered_list_engine; has no dependencies of its own.
`timescale 1ns / 1ps

package ola_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 4;
	localparam int POS_W    = 4;
	localparam int STAT_W   = 3;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 40;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 4'd0,
		OP_INS_BACK  = 4'd1,
		OP_INS_AFTER = 4'd2,
		OP_UPD_FRONT = 4'd3,
		OP_UPD_BACK  = 4'd4,
		OP_UPD_MATCH = 4'd5,
		OP_DEL_FRONT = 4'd6,
		OP_DEL_BACK  = 4'd7,
		OP_DEL_MATCH = 4'd8,
		OP_READ      = 4'd9
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_NOT_FOUND = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_BAD_POS   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MOVE,
		S_WRITE,
		S_READ,
		S_FINISH
	} state_t;

	typedef struct packed {
		state_t              state;
		status_t             status;
		logic [CNT_W-1:0]    count;
		logic [ADDR_W-1:0]   wr_idx;
		logic                mv_start;
		logic                mv_up;
		logic [ADDR_W-1:0]   mv_src;
		logic [ADDR_W-1:0]   mv_last;
	} plan_t;

endpackage

FILE: rtl/ola_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ola_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/ordered_list_engine.sv
// Ordered list engine top level: sequencer, element store and output register.
// Depends on ola_pkg and ola_ram.
`timescale 1ns / 1ps

// The engine holds an ordered list of up to CAPACITY signed 32-bit values in a
// single-port-read, single-port-write RAM and handles one request at a time.
// Each request yields exactly one result word with a status, the value read
// (zero unless a read succeeds) and the element count after the request.
// Operations that touch no stored entry go from decode straight to finish;
// front/back updates, reads and back inserts pass through one write or read
// state; a key search over the held entries may be followed by a shift of
// the entries behind the hit. The search reads one entry per cycle and the
// shift moves one entry per cycle through the one RAM read port and the one
// write port, so those two walks set the cost; together they visit each held
// entry once. A finished result sits in an output register, so the next
// request is taken while it waits. No clearing pass runs after reset; entries
// beyond the element count never reach a result.

module ordered_list_engine
	import ola_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// operation[3:0], value[35:4], key[67:36], position[71:68]
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// status[2:0], read_value[34:3], element_count[39:35]
	output logic [OUT_W-1:0] m_axis_tdata
);

	state_t              state_q;
	plan_t               plan;
	logic [CNT_W-1:0]    count_q;
	logic [OP_W-1:0]     op_q;
	logic [VALUE_W-1:0]  value_q;
	logic [VALUE_W-1:0]  key_q;
	logic [POS_W-1:0]    pos_q;
	status_t             status_q;
	logic [VALUE_W-1:0]  rd_q;
	logic [ADDR_W-1:0]   wr_idx_q;

	logic [CNT_W-1:0]    ridx_q;
	logic [ADDR_W-1:0]   cidx_q;
	logic                cvalid_q;

	logic                mv_iss_q;
	logic                mv_pend_q;
	logic                mv_up_q;
	logic [ADDR_W-1:0]   mv_src_q;
	logic [ADDR_W-1:0]   mv_last_q;
	logic [ADDR_W-1:0]   mv_dst_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [VALUE_W-1:0]  out_rd_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;

	logic                full;
	logic                empty;
	logic [CNT_W-1:0]    c_m1;
	logic [CNT_W-1:0]    c_p1;
	logic                hit;
	logic                tail;
	logic                in_accept;
	logic                out_free;

	ola_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign c_m1      = CNT_W'(count_q - 1'b1);
	assign c_p1      = CNT_W'(count_q + 1'b1);
	assign hit       = cvalid_q && (ram_rdata == key_q);
	assign tail      = cvalid_q && (CNT_W'(cidx_q) == c_m1);
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	// Next state together with the setup of the registers for the next phase.
	always_comb begin
		plan.state    = state_q;
		plan.status   = status_q;
		plan.count    = count_q;
		plan.wr_idx   = wr_idx_q;
		plan.mv_start = 1'b0;
		plan.mv_up    = mv_up_q;
		plan.mv_src   = mv_src_q;
		plan.mv_last  = mv_last_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					plan.state = S_DECODE;
				end
			end
			S_DECODE: begin
				plan.status = STAT_OK;
				plan.state  = S_FINISH;
				case (op_q)
					OP_INS_FRONT: begin
						if (full) begin
							plan.status = STAT_FULL;
						end else begin
							plan.count  = c_p1;
							plan.wr_idx = '0;
							if (empty) begin
								plan.state = S_WRITE;
							end else begin
								plan.state    = S_MOVE;
								plan.mv_start = 1'b1;
								plan.mv_up    = 1'b1;
								plan.mv_src   = c_m1[ADDR_W-1:0];
								plan.mv_last  = '0;
							end
						end
					end
					OP_INS_BACK: begin
						if (full) begin
							plan.status = STAT_FULL;
						end else begin
							plan.count  = c_p1;
							plan.wr_idx = count_q[ADDR_W-1:0];
							plan.state  = S_WRITE;
						end
					end
					OP_INS_AFTER: begin
						if (full) begin
							plan.status = STAT_FULL;
						end else if (empty) begin
							plan.status = STAT_NOT_FOUND;
						end else begin
							plan.state = S_SCAN;
						end
					end
					OP_UPD_FRONT: begin
						if (empty) begin
							plan.status = STAT_EMPTY;
						end else begin
							plan.wr_idx = '0;
							plan.state  = S_WRITE;
						end
					end
					OP_UPD_BACK: begin
						if (empty) begin
							plan.status = STAT_EMPTY;
						end else begin
							plan.wr_idx = c_m1[ADDR_W-1:0];
							plan.state  = S_WRITE;
						end
					end
					OP_UPD_MATCH, OP_DEL_MATCH: begin
						if (empty) begin
							plan.status = STAT_NOT_FOUND;
						end else begin
							plan.state = S_SCAN;
						end
					end
					OP_DEL_FRONT: begin
						if (empty) begin
							plan.status = STAT_EMPTY;
						end else begin
							plan.count = c_m1;
							if (c_m1 != '0) begin
								plan.state    = S_MOVE;
								plan.mv_start = 1'b1;
								plan.mv_up    = 1'b0;
								plan.mv_src   = ADDR_W'(1);
								plan.mv_last  = c_m1[ADDR_W-1:0];
							end
						end
					end
					OP_DEL_BACK: begin
						if (empty) begin
							plan.status = STAT_EMPTY;
						end else begin
							plan.count = c_m1;
						end
					end
					OP_READ: begin
						if (CMP_W'(pos_q) >= CMP_W'(count_q)) begin
							plan.status = STAT_BAD_POS;
						end else begin
							plan.state = S_READ;
						end
					end
					default: begin
						plan.state = S_FINISH;
					end
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					case (op_q)
						OP_UPD_MATCH: begin
							plan.wr_idx = cidx_q;
							plan.state  = S_WRITE;
						end
						OP_INS_AFTER: begin
							plan.count  = c_p1;
							plan.wr_idx = ADDR_W'(cidx_q + 1'b1);
							if (tail) begin
								plan.state = S_WRITE;
							end else begin
								plan.state    = S_MOVE;
								plan.mv_start = 1'b1;
								plan.mv_up    = 1'b1;
								plan.mv_src   = c_m1[ADDR_W-1:0];
								plan.mv_last  = ADDR_W'(cidx_q + 1'b1);
							end
						end
						OP_DEL_MATCH: begin
							plan.count = c_m1;
							if (tail) begin
								plan.state = S_FINISH;
							end else begin
								plan.state    = S_MOVE;
								plan.mv_start = 1'b1;
								plan.mv_up    = 1'b0;
								plan.mv_src   = ADDR_W'(cidx_q + 1'b1);
								plan.mv_last  = c_m1[ADDR_W-1:0];
							end
						end
						default: begin
							plan.state = S_FINISH;
						end
					endcase
				end else if (tail) begin
					plan.status = STAT_NOT_FOUND;
					plan.state  = S_FINISH;
				end
			end
			S_MOVE: begin
				// The last pending word is written back in this cycle.
				if (!mv_iss_q) begin
					plan.state = mv_up_q ? S_WRITE : S_FINISH;
				end
			end
			S_WRITE: begin
				plan.state = S_FINISH;
			end
			S_READ: begin
				plan.state = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					plan.state = S_IDLE;
				end
			end
			default: begin
				plan.state = S_IDLE;
			end
		endcase
	end

	// RAM port control and input handshake.
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		ram_we        = 1'b0;
		ram_waddr     = wr_idx_q;
		ram_wdata     = value_q;
		ram_raddr     = '0;
		case (state_q)
			S_DECODE: begin
				ram_raddr = ADDR_W'(pos_q);
			end
			S_SCAN: begin
				ram_raddr = ridx_q[ADDR_W-1:0];
			end
			S_MOVE: begin
				ram_raddr = mv_src_q;
				ram_we    = mv_pend_q;
				ram_waddr = mv_dst_q;
				ram_wdata = ram_rdata;
			end
			S_WRITE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cvalid_q    <= 1'b0;
			mv_iss_q    <= 1'b0;
			mv_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= plan.state;
			count_q <= plan.count;
			if (state_q == S_SCAN) begin
				cvalid_q <= 1'b1;
			end else begin
				cvalid_q <= 1'b0;
			end
			if (plan.mv_start) begin
				mv_iss_q  <= 1'b1;
				mv_pend_q <= 1'b0;
			end else if (state_q == S_MOVE) begin
				mv_pend_q <= mv_iss_q;
				if (mv_iss_q && (mv_src_q == mv_last_q)) begin
					mv_iss_q <= 1'b0;
				end
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= s_axis_tdata[3:0];
			value_q <= s_axis_tdata[35:4];
			key_q   <= s_axis_tdata[67:36];
			pos_q   <= s_axis_tdata[71:68];
		end
		status_q  <= plan.status;
		wr_idx_q  <= plan.wr_idx;
		mv_up_q   <= plan.mv_up;
		mv_last_q <= plan.mv_last;
		if (state_q == S_DECODE) begin
			rd_q   <= '0;
			ridx_q <= '0;
		end
		if (state_q == S_READ) begin
			rd_q <= ram_rdata;
		end
		// The scan issues one read per cycle and compares the word read the cycle before.
		if (state_q == S_SCAN) begin
			ridx_q <= CNT_W'(ridx_q + 1'b1);
			cidx_q <= ridx_q[ADDR_W-1:0];
		end
		if (plan.mv_start) begin
			mv_src_q <= plan.mv_src;
		end else if (state_q == S_MOVE && mv_iss_q) begin
			mv_dst_q <= mv_up_q ? ADDR_W'(mv_src_q + 1'b1) : ADDR_W'(mv_src_q - 1'b1);
			if (mv_src_q != mv_last_q) begin
				mv_src_q <= mv_up_q ? ADDR_W'(mv_src_q - 1'b1) : ADDR_W'(mv_src_q + 1'b1);
			end
		end
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= status_q;
			out_rd_q     <= rd_q;
			out_cnt_q    <= count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_cnt_q, out_rd_q, out_status_q};

endmodule

FILE: bench/ola_list_checker.sv
`timescale 1ns / 1ps
// Result checker for ordered_list_engine: keeps its own copy of the list.
// It predicts every result word and compares it with the engine. Depends on ola_pkg.

module ola_list_checker
	import ola_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  logic [IN_W-1:0]  req_data,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  logic [OUT_W-1:0] rsp_data,
	output int               mismatches,
	output int               outstanding,
	output int               words_checked,
	output logic [4:0]       statuses_seen,
	output int               deepest_list
);

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] read_value;
		logic [CNT_W-1:0]   count;
	} list_result_t;

	logic [VALUE_W-1:0] shadow_list [CAPACITY];
	int                 shadow_len;
	int                 error_tally;
	int                 checked_tally;
	list_result_t       awaited [$];

	function automatic void shift_in(int at, logic [VALUE_W-1:0] val);
		int i;
		for (i = shadow_len; i > at; i--)
			shadow_list[i] = shadow_list[i-1];
		shadow_list[at] = val;
		shadow_len++;
	endfunction

	function automatic void shift_out(int at);
		int i;
		for (i = at; i < shadow_len - 1; i++)
			shadow_list[i] = shadow_list[i+1];
		shadow_len--;
	endfunction

	// Applies one request to the shadow list and returns the word the engine owes.
	function automatic list_result_t apply_request(logic [OP_W-1:0] op,
			logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] key, logic [POS_W-1:0] pos);
		list_result_t r;
		int hit;
		int i;
		r.status = STAT_OK;
		r.read_value = '0;
		// The first match from the front wins; no match leaves hit at the length.
		hit = shadow_len;
		for (i = shadow_len - 1; i >= 0; i--)
			if (shadow_list[i] == key)
				hit = i;
		case (op_t'(op))
			OP_INS_FRONT: begin
				if (shadow_len >= CAPACITY) r.status = STAT_FULL;
				else shift_in(0, val);
			end
			OP_INS_BACK: begin
				if (shadow_len >= CAPACITY) r.status = STAT_FULL;
				else shift_in(shadow_len, val);
			end
			OP_INS_AFTER: begin
				// A full list is reported before the key is even looked for.
				if (shadow_len >= CAPACITY) r.status = STAT_FULL;
				else if (hit == shadow_len) r.status = STAT_NOT_FOUND;
				else shift_in(hit + 1, val);
			end
			OP_UPD_FRONT: begin
				if (shadow_len == 0) r.status = STAT_EMPTY;
				else shadow_list[0] = val;
			end
			OP_UPD_BACK: begin
				if (shadow_len == 0) r.status = STAT_EMPTY;
				else shadow_list[shadow_len-1] = val;
			end
			OP_UPD_MATCH: begin
				if (hit == shadow_len) r.status = STAT_NOT_FOUND;
				else shadow_list[hit] = val;
			end
			OP_DEL_FRONT: begin
				if (shadow_len == 0) r.status = STAT_EMPTY;
				else shift_out(0);
			end
			OP_DEL_BACK: begin
				if (shadow_len == 0) r.status = STAT_EMPTY;
				else shift_out(shadow_len - 1);
			end
			OP_DEL_MATCH: begin
				if (hit == shadow_len) r.status = STAT_NOT_FOUND;
				else shift_out(hit);
			end
			OP_READ: begin
				if (int'(pos) >= shadow_len) r.status = STAT_BAD_POS;
				else r.read_value = shadow_list[pos];
			end
			default: begin
				// Unused codes leave the list alone and answer ok.
			end
		endcase
		r.count = CNT_W'(shadow_len);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			shadow_len = 0;
			error_tally = 0;
			checked_tally = 0;
			awaited.delete();
			mismatches <= 0;
			outstanding <= 0;
			words_checked <= 0;
			statuses_seen <= '0;
			deepest_list <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got.status = status_t'(rsp_data[2:0]);
				got.read_value = rsp_data[34:3];
				got.count = rsp_data[39:35];
				if (awaited.size() == 0) begin
					$error("result word arrived with no request outstanding");
					error_tally++;
				end else begin
					want = awaited.pop_front();
					checked_tally++;
					if (got.status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						error_tally++;
					end
					if (got.read_value != want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							$signed(want.read_value), $signed(got.read_value));
						error_tally++;
					end
					if (got.count != want.count) begin
						$error("element_count: expected %0d, got %0d", want.count, got.count);
						error_tally++;
					end
				end
				if (rsp_data[2:0] < 3'd5)
					statuses_seen[rsp_data[2:0]] <= 1'b1;
			end
			if (req_valid && req_ready) begin
				awaited.push_back(apply_request(req_data[3:0], req_data[35:4],
					req_data[67:36], req_data[71:68]));
				if (shadow_len > deepest_list)
					deepest_list <= shadow_len;
			end
			mismatches <= error_tally;
			words_checked <= checked_tally;
			outstanding <= awaited.size();
		end
	end

endmodule

FILE: bench/ordered_list_engine_test.sv
`timescale 1ns / 1ps
// Testbench top for ordered_list_engine: clock, reset, request stimulus and verdict.
// Depends on ola_pkg, ordered_list_engine and ola_list_checker.

module ordered_list_engine_test;
	import ola_pkg::*;

	localparam int LIMIT_CYCLES    = 500000;
	localparam int RANDOM_REQUESTS = 1250;
	localparam int PHASE_LEN       = 120;
	localparam logic [OP_W-1:0]    OP_UNUSED_LO = 4'd10;
	localparam logic [OP_W-1:0]    OP_UNUSED_HI = 4'd15;
	localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tready = 1'b0;
	wire              s_axis_tready;
	wire              m_axis_tvalid;
	wire [OUT_W-1:0]  m_axis_tdata;

	int               mismatches;
	int               outstanding;
	int               words_checked;
	int               deepest_list;
	logic [4:0]       statuses_seen;

	int               cycle_count = 0;
	int               burst_left = 0;
	int               requests_sent = 0;
	int               stall_left = 0;
	logic [1:0]       stall_mode = 2'd0;
	logic [15:0]      stall_mask = 16'hFFFF;
	logic [3:0]       stall_phase = 4'd0;
	logic [VALUE_W-1:0] value_pool [8];

	ordered_list_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ola_list_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (s_axis_tvalid),
		.req_ready     (s_axis_tready),
		.req_data      (s_axis_tdata),
		.rsp_valid     (m_axis_tvalid),
		.rsp_ready     (m_axis_tready),
		.rsp_data      (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.statuses_seen (statuses_seen),
		.deepest_list  (deepest_list)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, outstanding);
			$display("TB_ERROR");
			$finish;
		end
	end

	// The receiver switches between always ready, coin flips, a repeating mask
	// and rare stalls, each held for a random stretch of cycles.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 4'd1;
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_mask <= 16'($urandom) | 16'h0001;
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
			2'd2: m_axis_tready <= stall_mask[stall_phase];
			default: m_axis_tready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Mostly values from a small pool so that key searches hit often.
	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return value_pool[$urandom_range(0, 7)];
	endfunction

	// Sends one request word; the sender sometimes idles between bursts of random length.
	task automatic issue_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
			logic [VALUE_W-1:0] key, logic [POS_W-1:0] pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pos, key, val, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		requests_sent++;
	endtask

	initial begin : stimulus
		int taken;
		int roll;
		int ins_pct;
		int del_pct;
		int phase;
		logic [OP_W-1:0] op;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = VAL_NEG1;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every operation but the back insert on an empty list, then a short list with extreme values.
		issue_request(OP_READ, '0, '0, 4'd0);
		issue_request(OP_UPD_FRONT, 32'd1, '0, 4'd0);
		issue_request(OP_UPD_BACK, 32'd2, '0, 4'd0);
		issue_request(OP_DEL_FRONT, '0, '0, 4'd0);
		issue_request(OP_DEL_BACK, '0, '0, 4'd0);
		issue_request(OP_DEL_MATCH, '0, '0, 4'd0);
		issue_request(OP_UPD_MATCH, 32'd3, '0, 4'd0);
		issue_request(OP_INS_AFTER, 32'd4, '0, 4'd0);
		issue_request(OP_INS_FRONT, VAL_MIN, '0, 4'd0);
		issue_request(OP_INS_BACK, VAL_MAX, '0, 4'd0);
		issue_request(OP_INS_AFTER, '0, VAL_MIN, 4'd0);
		issue_request(OP_INS_AFTER, VAL_NEG1, VAL_MAX, 4'd0);
		issue_request(OP_INS_AFTER, 32'd7, 32'd5, 4'd0);
		issue_request(OP_READ, '0, '0, 4'd3);
		issue_request(OP_READ, '0, '0, 4'd15);
		issue_request(OP_READ, '0, '0, 4'd4);
		issue_request(OP_UPD_MATCH, 32'h5A5A_A5A5, '0, 4'd0);
		issue_request(OP_UPD_FRONT, VAL_MAX, '0, 4'd0);
		issue_request(OP_UPD_BACK, VAL_MIN, '0, 4'd0);
		issue_request(OP_DEL_MATCH, '0, VAL_MAX, 4'd0);
		issue_request(OP_UNUSED_HI, VAL_NEG1, VAL_NEG1, 4'd15);
		issue_request(OP_UNUSED_LO, '0, '0, 4'd0);
		issue_request(OP_DEL_FRONT, '0, '0, 4'd0);
		issue_request(OP_DEL_BACK, '0, '0, 4'd0);
		issue_request(OP_READ, '0, '0, 4'd0);

		// Random part cycles through filling, mixed and draining phases, so the
		// list runs into full inserts and back down to empty several times.
		taken = 0;
		while (taken < RANDOM_REQUESTS) begin
			phase = (taken / PHASE_LEN) % 3;
			ins_pct = (phase == 0) ? 55 : (phase == 2) ? 12 : 30;
			del_pct = (phase == 0) ? 12 : (phase == 2) ? 55 : 30;
			if ($urandom_range(0, 149) == 0)
				value_pool[$urandom_range(4, 7)] = $urandom;
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				op = OP_INS_FRONT + OP_W'($urandom_range(0, 2));
			else if (roll < ins_pct + del_pct)
				op = OP_DEL_FRONT + OP_W'($urandom_range(0, 2));
			else if (roll < 93)
				op = roll[0] ? OP_UPD_FRONT + OP_W'($urandom_range(0, 2)) : OP_READ;
			else
				op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			issue_request(op, pick_value(), pick_value(), POS_W'($urandom_range(0, 15)));
			taken++;
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Ran %0d requests through the list and checked %0d result words.",
			requests_sent, words_checked);
		$display("Statuses seen (bit per code) %05b; longest list held %0d of %0d.",
			statuses_seen, deepest_list, CAPACITY);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
